>>> rtl/pqmq_pkg.sv
// Package for the priority quantum multi-queue scheduler.
// Holds request and result types, status codes, sequencer states and defaults.
// No dependencies.
`default_nettype none
package pqmq_pkg;

    localparam int DEF_NUM_QUEUES  = 4;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam logic [1:0] REG_QUEUES_IN_USE = 2'd0;
    localparam logic [1:0] REG_QUANTUM       = 2'd1;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_DROPPED   = 3'd1;
    localparam logic [2:0] ST_IDLE_TICK = 3'd2;
    localparam logic [2:0] ST_REQUEUED  = 3'd3;
    localparam logic [2:0] ST_COMPLETED = 3'd4;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] request_id;
        logic [7:0]  priority_req;
        logic [15:0] svc_time;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_request_id;
        logic [1:0]  queue_index;
    } t_out;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [15:0] service;
        logic [15:0] spent;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIN_SCAN,
        S_PUSH,
        S_PRIO_SCAN,
        S_POP_RD,
        S_POP
    } t_state;

endpackage
`default_nettype wire

>>> rtl/pqmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pqmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/priority_quantum_multi_queue_scheduler.sv
// Top level of the priority quantum multi-queue scheduler.
// Depends on pqmq_pkg and pqmq_ram.
`default_nettype none
// Usage:
// A request is accepted when start is high and busy is low. An add request
// places a new entry at the tail of the shortest active queue; a tick request
// serves the head with the highest priority, adds one quantum to its spent
// time and either completes it or moves it to the shortest active queue.
// Exactly one result follows each request, shown for one cycle with
// o_res_valid; the receiver cannot stall, so the result must be taken then.
// Job length is set by one queue scan per cycle over the count registers and
// by the single read port of the entry memory, which returns head entries in
// the cycle after their address.
// busy is high during the whole job, so one request is in flight at a time;
// the next may be accepted in the cycle its result is shown.
// Configuration writes go through i_cfg_valid/o_cfg_ready, which is always
// ready; write only while the block is idle. Reset clears all pointers and
// counts and restores four active queues and a quantum of one; the entry
// memory needs no clearing since entries of empty queues are never used.
module priority_quantum_multi_queue_scheduler
    import pqmq_pkg::*;
#(
    parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_in         i_req,
    output logic             o_res_valid,
    output t_out             o_res,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    localparam int QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int NW   = $clog2(NUM_QUEUES + 1);
    localparam int PW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW   = $clog2(SLOTS);
    localparam int EW   = $bits(t_entry);
    localparam int KW   = (NW > 3) ? NW : 3;

    // Configuration registers.
    logic [2:0]  r_queues_in_use;
    logic [15:0] r_quantum;

    // Queue bookkeeping.
    logic [PW-1:0] r_head [NUM_QUEUES];
    logic [PW-1:0] r_tail [NUM_QUEUES];
    logic [CW-1:0] r_cnt  [NUM_QUEUES];

    // Sequencer state.
    t_state        r_state, n_state;
    logic [NW-1:0] r_q, n_q;
    logic [QW-1:0] r_best, n_best;
    logic [CW-1:0] r_best_cnt, n_best_cnt;
    logic [7:0]    r_best_prio, n_best_prio;
    logic          r_found, n_found;
    logic          r_cmp_vld, n_cmp_vld;
    logic [QW-1:0] r_cmp_q, n_cmp_q;
    logic          r_is_tick, n_is_tick;
    t_entry        r_entry, n_entry;
    logic          r_out_vld, n_out_vld;
    t_out          r_out, n_out;

    logic          s_push, s_pop;
    logic [NW-1:0] s_active;
    logic [KW-1:0] s_cfg_wide;
    logic [QW-1:0] s_scan_idx;
    logic [QW-1:0] s_rd_q;
    logic [AW-1:0] s_raddr, s_waddr;
    t_entry        s_rdata;
    logic [16:0]   s_sum;
    logic [QW+1:0] s_best_wide;

    // Clamp the active queue count into one through NUM_QUEUES.
    always_comb begin
        s_cfg_wide = KW'(r_queues_in_use);
        if (r_queues_in_use == 3'd0) begin
            s_active = NW'(1);
        end else if (s_cfg_wide > KW'(NUM_QUEUES)) begin
            s_active = NW'(NUM_QUEUES);
        end else begin
            s_active = NW'(r_queues_in_use);
        end
    end

    assign s_scan_idx  = r_q[QW-1:0];
    assign s_rd_q      = (r_state == S_POP_RD) ? r_best : s_scan_idx;
    assign s_raddr     = AW'(s_rd_q * QUEUE_DEPTH) + AW'(r_head[s_rd_q]);
    assign s_waddr     = AW'(r_best * QUEUE_DEPTH) + AW'(r_tail[r_best]);
    assign s_sum       = {1'b0, s_rdata.spent} + {1'b0, r_quantum};
    assign s_best_wide = {2'b00, r_best};

    pqmq_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s_push),
        .i_waddr (s_waddr),
        .i_wdata (r_entry),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_q         = r_q;
        n_best      = r_best;
        n_best_cnt  = r_best_cnt;
        n_best_prio = r_best_prio;
        n_found     = r_found;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_q     = r_cmp_q;
        n_is_tick   = r_is_tick;
        n_entry     = r_entry;
        n_out_vld   = 1'b0;
        n_out       = r_out;
        s_push      = 1'b0;
        s_pop       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_q       = '0;
                    n_found   = 1'b0;
                    n_cmp_vld = 1'b0;
                    n_is_tick = (i_req.kind == KIND_TICK);
                    n_entry   = '{id: i_req.request_id, prio: i_req.priority_req,
                                  service: i_req.svc_time, spent: 16'd0};
                    n_state   = (i_req.kind == KIND_TICK) ? S_PRIO_SCAN : S_MIN_SCAN;
                end
            end
            S_MIN_SCAN: begin
                // One queue count per cycle; strict less-than keeps the lowest index.
                if (r_q == '0 || r_cnt[s_scan_idx] < r_best_cnt) begin
                    n_best     = s_scan_idx;
                    n_best_cnt = r_cnt[s_scan_idx];
                end
                if (r_q == s_active - NW'(1)) begin
                    n_state = S_PUSH;
                end else begin
                    n_q = r_q + NW'(1);
                end
            end
            S_PUSH: begin
                n_out_vld = 1'b1;
                n_state   = S_IDLE;
                if (!r_is_tick && r_best_cnt >= CW'(QUEUE_DEPTH)) begin
                    n_out = '{status: ST_DROPPED, out_request_id: r_entry.id,
                              queue_index: 2'd0};
                end else begin
                    s_push = 1'b1;
                    n_out  = '{status: r_is_tick ? ST_REQUEUED : ST_ADDED,
                               out_request_id: r_entry.id,
                               queue_index: s_best_wide[1:0]};
                end
            end
            S_PRIO_SCAN: begin
                // Head reads are issued one queue ahead of the compare.
                if (r_cmp_vld && r_cnt[r_cmp_q] != '0 &&
                    (!r_found || s_rdata.prio > r_best_prio)) begin
                    n_found     = 1'b1;
                    n_best      = r_cmp_q;
                    n_best_prio = s_rdata.prio;
                end
                if (r_q < s_active) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_q   = s_scan_idx;
                    n_q       = r_q + NW'(1);
                end else begin
                    n_cmp_vld = 1'b0;
                    if (!r_cmp_vld) begin
                        if (r_found) begin
                            n_state = S_POP_RD;
                        end else begin
                            n_out_vld = 1'b1;
                            n_out     = '{status: ST_IDLE_TICK, out_request_id: 16'd0,
                                          queue_index: 2'd0};
                            n_state   = S_IDLE;
                        end
                    end
                end
            end
            S_POP_RD: begin
                n_state = S_POP;
            end
            S_POP: begin
                s_pop = 1'b1;
                if (s_sum >= {1'b0, s_rdata.service}) begin
                    n_out_vld = 1'b1;
                    n_out     = '{status: ST_COMPLETED, out_request_id: s_rdata.id,
                                  queue_index: s_best_wide[1:0]};
                    n_state   = S_IDLE;
                end else begin
                    n_entry       = s_rdata;
                    n_entry.spent = s_sum[15:0];
                    n_q           = '0;
                    n_state       = S_MIN_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_vld       <= 1'b0;
            r_queues_in_use <= 3'd4;
            r_quantum       <= 16'd1;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && i_cfg_index == REG_QUEUES_IN_USE) begin
                r_queues_in_use <= i_cfg_data[2:0];
            end
            if (i_cfg_valid && i_cfg_index == REG_QUANTUM) begin
                r_quantum <= i_cfg_data;
            end
            if (s_push) begin
                r_tail[r_best] <= (r_tail[r_best] == PW'(QUEUE_DEPTH - 1)) ?
                                  '0 : r_tail[r_best] + PW'(1);
                r_cnt[r_best]  <= r_cnt[r_best] + CW'(1);
            end
            if (s_pop) begin
                r_head[r_best] <= (r_head[r_best] == PW'(QUEUE_DEPTH - 1)) ?
                                  '0 : r_head[r_best] + PW'(1);
                r_cnt[r_best]  <= r_cnt[r_best] - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q         <= n_q;
        r_best      <= n_best;
        r_best_cnt  <= n_best_cnt;
        r_best_prio <= n_best_prio;
        r_found     <= n_found;
        r_cmp_vld   <= n_cmp_vld;
        r_cmp_q     <= n_cmp_q;
        r_is_tick   <= n_is_tick;
        r_entry     <= n_entry;
        r_out       <= n_out;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("request accepted but block not busy");
    a_res_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid) else $error("result shown twice in a row");
    a_res_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy) else $error("result shown while job still running");
    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_push && s_pop)) else $error("push and pop in the same cycle");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_push |-> r_cnt[r_best] < CW'(QUEUE_DEPTH)) else $error("push into full queue");
`endif
endmodule
`default_nettype wire
